[hdl/irdc_pkg.sv]
// Shared types and constants for the interrupt read and debounce controller.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package irdc_pkg;

   // Field widths
   localparam int TimeWidth  = 16;
   localparam int StepWidth  = 8;
   localparam int ByteWidth  = 8;
   localparam int PinWidth   = 16;
   localparam int CodeWidth  = 2;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 16;

   // Packed stream widths, rounded up to whole bytes
   localparam int ReqBits  = 1 + 1 + 2 * ByteWidth + StepWidth;
   localparam int RspBits  = CodeWidth + 1 + PinWidth + CodeWidth;
   localparam int ReqWidth = ((ReqBits + 7) / 8) * 8;
   localparam int RspWidth = ((RspBits + 7) / 8) * 8;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_DATA_TIMEOUT   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_REPEAT_PERIOD  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_STABILITY_TIME = 2'd2;

   // Register reset values
   localparam logic [TimeWidth-1:0] DATA_TIMEOUT_RST   = 16'd10;
   localparam logic [TimeWidth-1:0] REPEAT_PERIOD_RST  = 16'd50;
   localparam logic [TimeWidth-1:0] STABILITY_TIME_RST = 16'd100;

   // Read request codes
   localparam logic [CodeWidth-1:0] REQ_NONE    = 2'd0;
   localparam logic [CodeWidth-1:0] REQ_CAPTURE = 2'd1;
   localparam logic [CodeWidth-1:0] REQ_PORT    = 2'd2;

   // Warning codes
   localparam logic [CodeWidth-1:0] WARN_NONE       = 2'd0;
   localparam logic [CodeWidth-1:0] WARN_DATA_TMO   = 2'd1;
   localparam logic [CodeWidth-1:0] WARN_CLEAR_TMO  = 2'd2;

   // Controller phase, one-hot
   typedef enum logic [4:0] {
      PH_START      = 5'b00001,
      PH_WAIT_INT   = 5'b00010,
      PH_WAIT_DATA  = 5'b00100,
      PH_DEBOUNCE   = 5'b01000,
      PH_WAIT_CLEAR = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [TimeWidth-1:0] data_timeout;
      logic [TimeWidth-1:0] repeat_period;
      logic [TimeWidth-1:0] stability_time;
   } cfg_type;

   typedef struct packed {
      phase_type            phase;
      logic [TimeWidth-1:0] elapsed;
      logic                 pending;
      logic [PinWidth-1:0]  latched;
   } state_type;

   typedef struct packed {
      logic                 int_level;
      logic                 read_done;
      logic [ByteWidth-1:0] data_low;
      logic [ByteWidth-1:0] data_high;
      logic [StepWidth-1:0] time_step;
   } item_type;

   typedef struct packed {
      logic [CodeWidth-1:0] read_request;
      logic                 update;
      logic [PinWidth-1:0]  pin_value;
      logic [CodeWidth-1:0] warning;
   } result_type;

endpackage

`default_nettype wire

[hdl/irdc_csr.sv]
// Configuration registers of the interrupt read and debounce controller.
// Depends on irdc_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module irdc_csr
   import irdc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DATA_TIMEOUT:   cfg_in.data_timeout   = csr_wdata;
            CSR_REPEAT_PERIOD:  cfg_in.repeat_period  = csr_wdata;
            CSR_STABILITY_TIME: cfg_in.stability_time = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_timeout   <= DATA_TIMEOUT_RST;
         cfg_ff.repeat_period  <= REPEAT_PERIOD_RST;
         cfg_ff.stability_time <= STABILITY_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hdl/irdc_step.sv]
// Next-state and result logic for one tick of the controller.
// Depends on irdc_pkg for phase, state, item and result types.
`default_nettype none

module irdc_step
   import irdc_pkg::*;
(
   input  wire cfg_type   cfg,
   input  wire state_type cur,
   input  wire item_type  item,
   output state_type  nxt,
   output result_type res
);

   logic [TimeWidth:0]   sum;
   logic [TimeWidth-1:0] el_sat;
   logic                 pend;

   // Advance the saturating timer and note a completed read
   assign sum    = {1'b0, cur.elapsed} + {{(TimeWidth + 1 - StepWidth){1'b0}}, item.time_step};
   assign el_sat = sum[TimeWidth] ? {TimeWidth{1'b1}} : sum[TimeWidth-1:0];
   assign pend   = cur.pending | item.read_done;

   always_comb begin
      nxt              = cur;
      nxt.elapsed      = el_sat;
      nxt.pending      = pend;
      res.read_request = REQ_NONE;
      res.update       = 1'b0;
      res.warning      = WARN_NONE;

      unique case (cur.phase)
         PH_START: begin
            nxt.pending = 1'b0;
            nxt.phase   = PH_WAIT_INT;
         end
         PH_WAIT_INT: begin
            if (item.int_level) begin
               res.read_request = REQ_CAPTURE;
               nxt.elapsed      = '0;
               nxt.phase        = PH_WAIT_DATA;
            end
         end
         PH_WAIT_DATA: begin
            // Data wins over a timeout in the same tick; warning still shows
            if (el_sat >= cfg.data_timeout) begin
               res.warning = WARN_DATA_TMO;
               nxt.phase   = PH_START;
            end
            if (pend) begin
               if (item.read_done) nxt.latched = {item.data_high, item.data_low};
               nxt.pending = 1'b0;
               res.update  = 1'b1;
               nxt.elapsed = '0;
               nxt.phase   = PH_DEBOUNCE;
            end
         end
         PH_DEBOUNCE: begin
            // Stability test sees the timer after a port read request restarts it
            if (item.int_level && (el_sat >= cfg.repeat_period)) begin
               res.read_request = REQ_PORT;
               nxt.elapsed      = '0;
               nxt.phase        = PH_WAIT_CLEAR;
            end
            if (nxt.elapsed >= cfg.stability_time) nxt.phase = PH_WAIT_INT;
         end
         PH_WAIT_CLEAR: begin
            if (el_sat >= cfg.data_timeout) begin
               res.warning = WARN_CLEAR_TMO;
               nxt.phase   = PH_START;
            end
            if (pend) begin
               nxt.pending = 1'b0;
               nxt.elapsed = '0;
               nxt.phase   = PH_DEBOUNCE;
            end
         end
         default: ;
      endcase

      res.pin_value = nxt.latched;
   end

endmodule

`default_nettype wire

[hdl/interrupt_read_debounce_controller.sv]
// Top level of the interrupt read and debounce controller.
// Depends on irdc_pkg, irdc_csr and irdc_step.
//
// Usage: each transfer on the req_ channel is one tick: the interrupt line
// level, a read-completion strobe with two data bytes, and the time elapsed
// since the previous tick. Each tick yields exactly one transfer on the rsp_
// channel: the read to request (capture or port registers), an update flag,
// the latched 16-bit pin value and a timeout warning.
// The result of a tick is registered and held in the output register.
// Throughput: one tick per cycle while results are taken; the state and
// timer update together, so the state loop through irdc_step sets the rate.
// Reset returns the controller to its start phase with the timer, pending
// flag and pin value cleared, the registers at 10, 50 and 100, and the
// output register empty.
// A stalled receiver holds the result in the output register; a new tick is
// taken in the same cycle the held result is taken, so req_tready follows
// rsp_tready whenever a result is waiting.
// User must write registers via csr_ with no tick in flight; not enforced.
`default_nettype none

module interrupt_read_debounce_controller
   import irdc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Tick channel
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // tdata from bit 0: int_level, read_done, data_low[7:0], data_high[7:0],
   // time_step[7:0], zero fill
   input  wire logic [ReqWidth-1:0]     req_tdata,
   // Result channel
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // tdata from bit 0: read_request[1:0], update, pin_value[15:0],
   // warning[1:0], zero fill
   output logic [RspWidth-1:0]          rsp_tdata,
   // Configuration writes
   input  wire logic                    csr_we,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item;
   state_type  state_ff, state_in;
   result_type res_in, res_ff;
   logic       valid_ff, valid_in;
   logic       take;

   irdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Unpack the tick, first field in the low bits
   assign item.int_level = req_tdata[0];
   assign item.read_done = req_tdata[1];
   assign item.data_low  = req_tdata[2 +: ByteWidth];
   assign item.data_high = req_tdata[2 + ByteWidth +: ByteWidth];
   assign item.time_step = req_tdata[2 + 2 * ByteWidth +: StepWidth];

   irdc_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (item),
      .nxt  (state_in),
      .res  (res_in)
   );

   // Accept a tick whenever the output register is free or drains this cycle
   assign req_tready = !valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase   <= PH_START;
         state_ff.elapsed <= '0;
         state_ff.pending <= 1'b0;
         state_ff.latched <= '0;
         valid_ff         <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) state_ff <= state_in;
      end
   end

   // Hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (take) res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspWidth - RspBits){1'b0}}, res_ff.warning, res_ff.pin_value,
                        res_ff.update, res_ff.read_request};

endmodule

`default_nettype wire
